>>> sv/agm_pkg.sv
// ----------------------------------------------------------------------------
// Graph table package
// Types, codes and helper functions shared by the graph table core and its
// vertex cells.
// ----------------------------------------------------------------------------
package agm_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int KEY_W = 32;
	localparam int WEIGHT_W = 32;
	localparam int COL_W = 6;
	localparam int RESULT_CAP = 16;
	localparam int COUNT_MAX = 255;

	typedef enum logic [2:0] {
		OP_ADD_EDGE   = 3'd0,
		OP_ADJACENT   = 3'd1,
		OP_DEGREE     = 3'd2,
		OP_EDGE_COUNT = 3'd3,
		OP_LIST_KEY   = 3'd4,
		OP_LIST_INDEX = 3'd5,
		OP_LOOKUP     = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_EXEC,
		S_COUNT,
		S_LIST
	} state_t;

	typedef struct packed {
		logic [2:0]                 opcode;
		logic [KEY_W-1:0]           key_a;
		logic [KEY_W-1:0]           key_b;
		logic signed [WEIGHT_W-1:0] weight_in;
		logic [3:0]                 vertex_index;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic                       flag;
		logic [3:0]                 found_index;
		logic signed [WEIGHT_W-1:0] weight_out;
		logic [7:0]                 count_out;
		logic [KEY_W-1:0]           neighbour_key;
		logic                       neighbour_valid;
		logic [4:0]                 vertex_count;
		logic                       last;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key_a;
		logic [KEY_W-1:0]    key_b;
		logic [WEIGHT_W-1:0] weight;
		logic [COL_W-1:0]    col_a;
		logic [COL_W-1:0]    col_b;
		logic [COL_W-1:0]    rd_col;
		logic                chain_clr;
		logic                chain_en;
	} cell_cmd_t;

	typedef struct packed {
		logic key_we;
		logic key_sel;
		logic we_a;
		logic we_b;
	} cell_ctl_t;

	function automatic logic [6:0] popcnt64(input logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			n = n + 7'(v[i]);
		end
		return n;
	endfunction

endpackage

>>> sv/adjacency_matrix_graph_table_core.sv
// Most requests go through the match and execute states to a registered result;
// an edge count also steps the count chain through the cells before its result.
// A neighbour listing walks one matrix column per cycle over the registered vertices.
// One request is in progress at a time; busy stays high until its last result,
// and a new request can be taken at that edge.
// Reset clears the vertex count and every present bit at once; no clearing pass.
// ----------------------------------------------------------------------------
// Graph table core
// Undirected weighted graph kept as a row of vertex cells, each holding one
// key and one matrix row, driven by a small sequencer.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_table_core
	import agm_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic rsp_strobe,
	output rsp_t rsp
);

	localparam int N = MAX_VERTICES;
	localparam int IDXW = (N > 1) ? $clog2(N) : 1;
	localparam int CNTW = $clog2(N + 1);
	localparam int SUMW = $clog2(N * (N + 1) / 2 + 1);
	localparam int NW = $clog2(RESULT_CAP);

	state_t state_q, state_d;
	req_t   req_q;
	logic [CNTW-1:0] used_q, used_d;
	logic [N-1:0]    hit_a_q, hit_b_q;
	logic [IDXW-1:0] col_q, col_d, row_sel_q, row_sel_d;
	logic [NW-1:0]   n_q, n_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	rsp_t rsp_q, rsp_d;
	logic strobe_q, emit;

	cell_cmd_t cmd;
	cell_ctl_t ctl [N];
	logic [N-1:0]        match_a, match_b, valid_v;
	logic [KEY_W-1:0]    keys [N];
	logic [N-1:0]        rows [N];
	logic [WEIGHT_W-1:0] wts [N];
	logic [SUMW-1:0]     sums [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		agm_cell #(.N(N), .INDEX(i), .SUMW(SUMW)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl[i]), .valid(valid_v[i]),
			.sum_in((i == 0) ? SUMW'(0) : sums[(i == 0) ? 0 : i - 1]),
			.match_a(match_a[i]), .match_b(match_b[i]), .key_out(keys[i]),
			.row_out(rows[i]), .rd_weight(wts[i]), .sum_out(sums[i])
		);
	end

	logic [IDXW-1:0] ia, ib, ia_n, ib_n, vi_idx, start_row;
	logic miss_a, miss_b, same, full, vi_ok, any_nb, present, more, last_l;
	logic [1:0] need;
	logic [N-1:0] used_mask, above, sel_row;

	always_comb begin
		ia = '0;
		ib = '0;
		for (int i = 0; i < N; i++) begin
			valid_v[i]   = (CNTW'(i) < used_q);
			used_mask[i] = valid_v[i];
			above[i]     = (IDXW'(i) > col_q) && (i < N);
			if (hit_a_q[i]) ia = ia | IDXW'(i);
			if (hit_b_q[i]) ib = ib | IDXW'(i);
		end
		miss_a = !(|hit_a_q);
		miss_b = !(|hit_b_q);
		same   = (req_q.key_a == req_q.key_b);
		need   = 2'(miss_a) + 2'(miss_b && !same);
		full   = (32'(used_q) + 32'(need)) > N;
		ia_n   = miss_a ? IDXW'(used_q) : ia;
		ib_n   = !miss_b ? ib : (same ? ia_n : IDXW'(used_q + CNTW'(miss_a)));
		vi_ok  = 32'(req_q.vertex_index) < 32'(used_q);
		vi_idx = IDXW'(req_q.vertex_index);
		start_row = (op_t'(req_q.opcode) == OP_LIST_KEY) ? ia : vi_idx;
		any_nb  = |(rows[start_row] & used_mask);
		sel_row = rows[row_sel_q];
		present = sel_row[col_q];
		more    = |(sel_row & used_mask & above);
		last_l  = !more || (32'(n_q) == RESULT_CAP - 1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_MATCH;
			end
			S_MATCH: state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_IDLE;
				case (op_t'(req_q.opcode))
					OP_EDGE_COUNT: state_d = S_COUNT;
					OP_LIST_KEY: if (!miss_a && any_nb) state_d = S_LIST;
					OP_LIST_INDEX: if (vi_ok && any_nb) state_d = S_LIST;
					default: state_d = S_IDLE;
				endcase
			end
			S_COUNT: begin
				if (32'(cnt_q) == N) state_d = S_IDLE;
			end
			S_LIST: begin
				if (present && last_l) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		emit = 1'b0;
		used_d = used_q;
		col_d = col_q;
		row_sel_d = row_sel_q;
		n_d = n_q;
		cnt_d = cnt_q;
		cmd.key_a = req_q.key_a;
		cmd.key_b = req_q.key_b;
		cmd.weight = req_q.weight_in;
		cmd.col_a = COL_W'(ib_n);
		cmd.col_b = COL_W'(ia_n);
		cmd.rd_col = (state_q == S_LIST) ? COL_W'(col_q) : COL_W'(ib);
		cmd.chain_clr = 1'b0;
		cmd.chain_en = 1'b0;
		for (int i = 0; i < N; i++) ctl[i] = '0;
		case (state_q)
			S_EXEC: begin
				emit = 1'b1;
				rsp_d.last = 1'b1;
				case (op_t'(req_q.opcode))
					OP_ADD_EDGE: begin
						if (full) begin
							rsp_d.status = ST_FULL;
						end else begin
							used_d = used_q + CNTW'(need);
							if (miss_a) ctl[ia_n].key_we = 1'b1;
							if (miss_b && !same) begin
								ctl[ib_n].key_we = 1'b1;
								ctl[ib_n].key_sel = 1'b1;
							end
							ctl[ia_n].we_a = 1'b1;
							ctl[ib_n].we_b = 1'b1;
						end
					end
					OP_ADJACENT: begin
						if (miss_a || miss_b) begin
							rsp_d.status = ST_NOT_FOUND;
						end else if (rows[ia][ib]) begin
							rsp_d.flag = 1'b1;
							rsp_d.weight_out = wts[ia];
						end
					end
					OP_DEGREE: begin
						if (!vi_ok) rsp_d.status = ST_RANGE;
						else rsp_d.count_out = 8'(popcnt64(64'(rows[vi_idx])));
					end
					OP_EDGE_COUNT: begin
						emit = 1'b0;
						cmd.chain_clr = 1'b1;
						cnt_d = '0;
					end
					OP_LIST_KEY, OP_LIST_INDEX: begin
						if (op_t'(req_q.opcode) == OP_LIST_KEY && miss_a) begin
							rsp_d.status = ST_NOT_FOUND;
						end else if (op_t'(req_q.opcode) == OP_LIST_INDEX && !vi_ok) begin
							rsp_d.status = ST_RANGE;
						end else if (any_nb) begin
							emit = 1'b0;
							row_sel_d = start_row;
							col_d = '0;
							n_d = '0;
						end
					end
					OP_LOOKUP: begin
						if (miss_a) begin
							rsp_d.status = ST_NOT_FOUND;
						end else begin
							rsp_d.flag = 1'b1;
							rsp_d.found_index = 4'(ia);
						end
					end
					default: ;
				endcase
			end
			S_COUNT: begin
				if (32'(cnt_q) == N) begin
					emit = 1'b1;
					rsp_d.last = 1'b1;
					rsp_d.count_out = (32'(sums[N-1]) > COUNT_MAX) ? 8'(COUNT_MAX)
						: 8'(sums[N-1]);
				end else begin
					cmd.chain_en = 1'b1;
					cnt_d = cnt_q + CNTW'(1);
				end
			end
			S_LIST: begin
				col_d = col_q + IDXW'(1);
				if (present) begin
					emit = 1'b1;
					n_d = n_q + NW'(1);
					rsp_d.weight_out = wts[row_sel_q];
					rsp_d.neighbour_key = keys[col_q];
					rsp_d.neighbour_valid = 1'b1;
					rsp_d.last = last_l;
				end
			end
			default: ;
		endcase
		rsp_d.vertex_count = 5'(used_d);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		if (state_q == S_MATCH) begin
			hit_a_q <= match_a;
			hit_b_q <= match_b;
		end
		col_q <= col_d;
		row_sel_q <= row_sel_d;
		n_q <= n_d;
		cnt_q <= cnt_d;
		rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			strobe_q <= emit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign rsp_strobe = strobe_q;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && rsp_q.last |-> state_q == S_IDLE) else $error("last result while busy");
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !rsp_q.last |-> busy) else $error("partial result while idle");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_MATCH) else $error("request not taken");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= N) else $error("vertex count overflow");
`endif

endmodule

>>> sv/agm_cell.sv
// ----------------------------------------------------------------------------
// Graph table vertex cell
// Holds one vertex key, its matrix row of present bits and weights, and one
// stage of the edge count chain.
// ----------------------------------------------------------------------------
module agm_cell
	import agm_pkg::*;
#(
	parameter int N = MAX_VERTICES_DEF,
	parameter int INDEX = 0,
	parameter int SUMW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_cmd_t           cmd,
	input  cell_ctl_t           ctl,
	input  logic                valid,
	input  logic [SUMW-1:0]     sum_in,
	output logic                match_a,
	output logic                match_b,
	output logic [KEY_W-1:0]    key_out,
	output logic [N-1:0]        row_out,
	output logic [WEIGHT_W-1:0] rd_weight,
	output logic [SUMW-1:0]     sum_out
);

	localparam int IDXW = (N > 1) ? $clog2(N) : 1;

	logic [KEY_W-1:0]    key_q;
	logic [N-1:0]        row_q;
	logic [WEIGHT_W-1:0] wt_q [N];
	logic [SUMW-1:0]     sum_q;
	logic [N-1:0]        upper;
	logic [6:0]          local_cnt;

	always_comb begin
		for (int c = 0; c < N; c++) begin
			upper[c] = (c >= INDEX);
		end
		local_cnt = popcnt64(64'(row_q & upper));
	end

	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_q <= ctl.key_sel ? cmd.key_b : cmd.key_a;
		end
		if (ctl.we_a) begin
			wt_q[cmd.col_a[IDXW-1:0]] <= cmd.weight;
		end
		if (ctl.we_b) begin
			wt_q[cmd.col_b[IDXW-1:0]] <= cmd.weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			sum_q <= '0;
		end else begin
			if (ctl.we_a) begin
				row_q[cmd.col_a[IDXW-1:0]] <= 1'b1;
			end
			if (ctl.we_b) begin
				row_q[cmd.col_b[IDXW-1:0]] <= 1'b1;
			end
			if (cmd.chain_clr) begin
				sum_q <= '0;
			end else if (cmd.chain_en) begin
				sum_q <= sum_in + SUMW'(local_cnt);
			end
		end
	end

	assign match_a   = valid && (key_q == cmd.key_a);
	assign match_b   = valid && (key_q == cmd.key_b);
	assign key_out   = key_q;
	assign row_out   = row_q;
	assign rd_weight = wt_q[cmd.rd_col[IDXW-1:0]];
	assign sum_out   = sum_q;

endmodule

>>> tb/tb_adjacency_matrix_graph_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graph table core testbench
// Drives add, query, count, lookup and listing requests into the graph table
// core with random gaps, predicts every result from a behavioural copy of the
// key table and the edge matrix, and compares results in order.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_graph_table_core;
	import agm_pkg::*;

	localparam int NV = 16;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic rsp_strobe;
	rsp_t rsp;

	adjacency_matrix_graph_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .rsp_strobe(rsp_strobe), .rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	logic [KEY_W-1:0] graph_keys [NV];
	int unsigned graph_used;
	logic graph_edge [NV][NV];
	logic signed [WEIGHT_W-1:0] graph_weight [NV][NV];

	rsp_t pending_rsp [$];
	int unsigned fail_count;
	int unsigned cycle_count;
	logic [KEY_W-1:0] key_pool [24];

	function automatic rsp_t blank_rsp();
		rsp_t r;
		r = '0;
		r.vertex_count = 5'(graph_used);
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int find_vertex(logic [KEY_W-1:0] k);
		for (int i = 0; i < graph_used; i++)
			if (graph_keys[i] == k)
				return i;
		return -1;
	endfunction

	task automatic queue_rsp(rsp_t r);
		pending_rsp = {pending_rsp, r};
	endtask

	task automatic predict_list(int row);
		rsp_t r;
		int n;
		n = 0;
		for (int c = 0; c < graph_used; c++) begin
			if (graph_edge[row][c] && n < RESULT_CAP) begin
				r = blank_rsp();
				r.last = 1'b0;
				r.weight_out = graph_weight[row][c];
				r.neighbour_key = graph_keys[c];
				r.neighbour_valid = 1'b1;
				queue_rsp(r);
				n++;
			end
		end
		if (n == 0)
			queue_rsp(blank_rsp());
		else
			pending_rsp[pending_rsp.size()-1].last = 1'b1;
	endtask

	task automatic predict_graph(req_t q);
		rsp_t r;
		int ia, ib, need, cnt;
		ia = find_vertex(q.key_a);
		ib = find_vertex(q.key_b);
		r = blank_rsp();
		case (q.opcode)
			OP_ADD_EDGE: begin
				need = (ia < 0 ? 1 : 0) + ((ib < 0 && q.key_a != q.key_b) ? 1 : 0);
				if (graph_used + need > NV) begin
					r.status = ST_FULL;
				end else begin
					if (ia < 0) begin
						ia = graph_used;
						graph_keys[graph_used++] = q.key_a;
					end
					if (ib < 0) begin
						if (q.key_a == q.key_b) ib = ia;
						else begin
							ib = graph_used;
							graph_keys[graph_used++] = q.key_b;
						end
					end
					graph_edge[ia][ib] = 1'b1;
					graph_edge[ib][ia] = 1'b1;
					graph_weight[ia][ib] = q.weight_in;
					graph_weight[ib][ia] = q.weight_in;
					r = blank_rsp();
				end
			end
			OP_ADJACENT: begin
				if (ia < 0 || ib < 0) r.status = ST_NOT_FOUND;
				else if (graph_edge[ia][ib]) begin
					r.flag = 1'b1;
					r.weight_out = graph_weight[ia][ib];
				end
			end
			OP_DEGREE: begin
				if (q.vertex_index >= graph_used) r.status = ST_RANGE;
				else begin
					cnt = 0;
					for (int c = 0; c < NV; c++) cnt += graph_edge[q.vertex_index][c];
					r.count_out = 8'(cnt);
				end
			end
			OP_EDGE_COUNT: begin
				cnt = 0;
				for (int a = 0; a < NV; a++)
					for (int c = a; c < NV; c++) cnt += graph_edge[a][c];
				r.count_out = cnt > COUNT_MAX ? 8'(COUNT_MAX) : 8'(cnt);
			end
			OP_LIST_KEY: begin
				if (ia < 0) r.status = ST_NOT_FOUND;
				else begin
					predict_list(ia);
					return;
				end
			end
			OP_LIST_INDEX: begin
				if (q.vertex_index >= graph_used) r.status = ST_RANGE;
				else begin
					predict_list(q.vertex_index);
					return;
				end
			end
			OP_LOOKUP: begin
				if (ia < 0) r.status = ST_NOT_FOUND;
				else begin
					r.flag = 1'b1;
					r.found_index = 4'(ia);
				end
			end
			default: ;
		endcase
		queue_rsp(r);
	endtask

	task automatic send_request(req_t q, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= q;
		do @(posedge clk); while (busy);
		predict_graph(q);
	endtask

	task automatic send_checked(req_t q, rsp_t want);
		send_request(q, 0);
		if (pending_rsp[pending_rsp.size()-1] !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("Directed row predicted %h, table says %h",
					pending_rsp[pending_rsp.size()-1], want);
		end
	endtask

	function automatic req_t make_req(op_t op, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb,
			logic [WEIGHT_W-1:0] w, logic [3:0] vi);
		req_t q;
		q.opcode = op;
		q.key_a = ka;
		q.key_b = kb;
		q.weight_in = w;
		q.vertex_index = vi;
		return q;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_strobe) begin
			if (pending_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result %h", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Result mismatch: expected %h, actual %h", want, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("adjacency_matrix_graph_table_core: mismatch");
			$finish;
		end
	end

	typedef struct {
		req_t q;
		logic checked;
		rsp_t want;
	} dir_row_t;

	initial begin
		dir_row_t rows [$];
		dir_row_t d;
		rsp_t w;
		req_t q;
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		fail_count = 0;
		cycle_count = 0;
		graph_used = 0;
		for (int a = 0; a < NV; a++)
			for (int c = 0; c < NV; c++) begin
				graph_edge[a][c] = 1'b0;
				graph_weight[a][c] = '0;
			end
		for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		w = '0; w.last = 1'b1;
		d.checked = 1'b1;
		d.want = w; d.q = make_req(OP_EDGE_COUNT, 0, 0, 0, 0); rows = {rows, d};
		d.want = w; d.want.status = ST_RANGE;
		d.q = make_req(OP_DEGREE, 0, 0, 0, 15); rows = {rows, d};
		d.q = make_req(OP_LIST_INDEX, 0, 0, 0, 0); rows = {rows, d};
		d.want = w; d.want.status = ST_NOT_FOUND;
		d.q = make_req(OP_LOOKUP, '1, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_LIST_KEY, 0, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_ADJACENT, 0, '1, 0, 0); rows = {rows, d};
		d.want = w; d.q = make_req(op_t'(3'd7), '1, '1, '1, 15); rows = {rows, d};
		d.checked = 1'b0;
		d.q = make_req(OP_ADD_EDGE, 0, '1, 32'h8000_0000, 0); rows = {rows, d};
		d.q = make_req(OP_ADD_EDGE, '1, '1, 32'h7FFF_FFFF, 0); rows = {rows, d};
		d.q = make_req(OP_ADD_EDGE, 0, '1, 32'hFFFF_FFFF, 0); rows = {rows, d};
		d.q = make_req(OP_ADJACENT, '1, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_DEGREE, 0, 0, 0, 1); rows = {rows, d};
		d.q = make_req(OP_EDGE_COUNT, 0, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_LIST_KEY, '1, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_LIST_INDEX, 0, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_LOOKUP, '1, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_ADD_EDGE, 0, 0, 0, 0); rows = {rows, d};
		d.q = make_req(OP_DEGREE, 0, 0, 0, 15); rows = {rows, d};
		foreach (rows[i]) begin
			if (rows[i].checked) begin
				w = rows[i].want;
				w.vertex_count = 5'(graph_used);
				send_checked(rows[i].q, w);
			end else
				send_request(rows[i].q, $urandom_range(0, 3));
		end

		for (int n = 0; n < 500; n++) begin
			if (n == 250) begin
				start <= 1'b0;
				while (pending_rsp.size() != 0) @(posedge clk);
			end
			q = '0;
			q.key_a = key_pool[$urandom_range(0, 23)];
			q.key_b = key_pool[$urandom_range(0, 23)];
			if ($urandom_range(0, 9) == 0) q.key_a = $urandom;
			q.weight_in = $urandom;
			q.vertex_index = $urandom_range(0, 15);
			pick = $urandom_range(0, 99);
			if (pick < 40) q.opcode = OP_ADD_EDGE;
			else q.opcode = 3'($urandom_range(1, 7));
			send_request(q, (n % 100 < 20) ? 0 : $urandom_range(0, 19));
		end

		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("adjacency_matrix_graph_table_core: match");
		else
			$display("adjacency_matrix_graph_table_core: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
sv/agm_pkg.sv
sv/agm_cell.sv
sv/adjacency_matrix_graph_table_core.sv
tb/tb_adjacency_matrix_graph_table_core.sv
